@@ src/prd_pkg.sv @@
package prd_pkg;

	localparam int SAMPLE_BITS_DEF = 10;
	localparam int TIME_BITS_DEF   = 32;

	localparam int THRESH_BITS = 10;
	localparam int REFR_BITS   = 16;
	localparam int BPM_BITS    = 16;
	localparam int IVL_BITS    = 32;

	localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(650);
	localparam logic [REFR_BITS-1:0]   REFR_RESET   = REFR_BITS'(300);

	// twice the ms per minute, numerator of the rounded rate
	localparam int RATE_NUMER      = 120000;
	localparam int RATE_NUMER_BITS = 17;

	localparam int ADDR_BITS = 3;

	typedef enum logic {
		REG_THRESHOLD  = 1'b0,
		REG_REFRACTORY = 1'b1
	} reg_idx_t;

endpackage

@@ src/prd_divider.sv @@
module prd_divider
	import prd_pkg::*;
#(
	parameter int NUM_W = 33,
	parameter int DEN_W = 33,
	parameter int QUO_W = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] numer,
	input  logic [DEN_W-1:0] denom,
	output logic             done,
	output logic [QUO_W-1:0] quotient
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             running_q;
	logic             done_q;

	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             fits;

	// one restoring step per cycle, numerator bits shift in msb first
	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			done_q    <= 1'b0;
			cnt_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				running_q <= 1'b1;
				cnt_q     <= '0;
			end else if (running_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					running_q <= 1'b0;
					done_q    <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= numer;
			rem_q <= '0;
			den_q <= denom;
		end else if (running_q) begin
			quo_q <= {quo_q[NUM_W-2:0], fits};
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q[QUO_W-1:0];

endmodule

@@ src/pulse_rate_detector_core.sv @@
// channel   | valid        | ready        | payload
// ----------+--------------+--------------+-------------------------------
// sample    | sample_valid | sample_ready | sample_value, time_ms
// beat      | beat_valid   | beat_ready   | beats_per_minute, interval_ms
// apb       | psel/penable | pready       | paddr, pwdata, prdata
//
// a request that is no accepted beat does not hold the input off
// an accepted beat holds the input off while the NUM_W-bit divide runs and until the output register is free,
// NUM_W being one more than the wider of TIME_BITS and 17,
// with the shared restoring divider doing one quotient bit per cycle
// a finished result waits in the output register while the next request is taken
// reset clears control state and loads the register defaults
module pulse_rate_detector_core
	import prd_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int TIME_BITS   = TIME_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   sample_valid,
	output logic                   sample_ready,
	input  logic [SAMPLE_BITS-1:0] sample_value,
	input  logic [TIME_BITS-1:0]   time_ms,
	output logic                   beat_valid,
	input  logic                   beat_ready,
	output logic [BPM_BITS-1:0]    beats_per_minute,
	output logic [IVL_BITS-1:0]    interval_ms,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [ADDR_BITS-1:0]   paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	localparam int CMP_W = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;
	localparam int RFC_W = (TIME_BITS > REFR_BITS) ? TIME_BITS : REFR_BITS;
	localparam int NUM_W = ((TIME_BITS > RATE_NUMER_BITS) ? TIME_BITS : RATE_NUMER_BITS) + 1;
	localparam int DEN_W = TIME_BITS + 1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_HOLD = 3'b100
	} state_t;

	state_t                 state_q;
	logic [THRESH_BITS-1:0] thresh_q;
	logic [REFR_BITS-1:0]   refr_q;
	logic [SAMPLE_BITS-1:0] prev_q;
	logic [TIME_BITS-1:0]   last_beat_q;
	logic [TIME_BITS-1:0]   ivl_q;
	logic                   start_q;
	logic                   out_valid_q;
	logic [BPM_BITS-1:0]    bpm_q;
	logic [IVL_BITS-1:0]    out_ivl_q;

	logic                   accept;
	logic                   crossing;
	logic [TIME_BITS-1:0]   ivl;
	logic                   beat;
	logic                   div_done;
	logic [BPM_BITS-1:0]    div_quo;
	logic                   slot_free;
	logic                   cfg_wr;
	reg_idx_t               cfg_idx;

	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[2]);
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_comb begin
		case (cfg_idx)
			REG_THRESHOLD:  prdata = 32'(thresh_q);
			REG_REFRACTORY: prdata = 32'(refr_q);
			default:        prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
			refr_q   <= REFR_RESET;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_THRESHOLD:  thresh_q <= pwdata[THRESH_BITS-1:0];
				REG_REFRACTORY: refr_q   <= pwdata[REFR_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign sample_ready = (state_q == ST_IDLE);
	assign accept       = sample_valid & sample_ready;
	assign crossing     = (CMP_W'(sample_value) > CMP_W'(thresh_q)) &&
	                      (CMP_W'(prev_q) <= CMP_W'(thresh_q));
	assign ivl          = time_ms - last_beat_q;
	assign beat         = crossing && (RFC_W'(ivl) > RFC_W'(refr_q));
	assign slot_free    = !out_valid_q || beat_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_q      <= '0;
			last_beat_q <= '0;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (out_valid_q && beat_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						prev_q <= sample_value;
						if (beat) begin
							last_beat_q <= time_ms;
							start_q     <= 1'b1;
							state_q     <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						if (slot_free) begin
							out_valid_q <= 1'b1;
							state_q     <= ST_IDLE;
						end else begin
							state_q <= ST_HOLD;
						end
					end
				end
				ST_HOLD: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && beat) begin
			ivl_q <= ivl;
		end
		if (((state_q == ST_DIV) && div_done && slot_free) ||
		    ((state_q == ST_HOLD) && slot_free)) begin
			bpm_q     <= div_quo;
			out_ivl_q <= IVL_BITS'(ivl_q);
		end
	end

	prd_divider #(
		.NUM_W (NUM_W),
		.DEN_W (DEN_W),
		.QUO_W (BPM_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.numer    (NUM_W'(RATE_NUMER) + NUM_W'(ivl_q)),
		.denom    ({ivl_q, 1'b0}),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign beat_valid       = out_valid_q;
	assign beats_per_minute = bpm_q;
	assign interval_ms      = out_ivl_q;

endmodule

@@ sim/pulse_rate_detector_core_tb.sv @@
module pulse_rate_detector_core_tb
	import prd_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [BPM_BITS-1:0] bpm;
		logic [IVL_BITS-1:0] ivl;
	} beat_rec_t;

	class beat_scoreboard;
		logic [THRESH_BITS-1:0]     threshold;
		logic [REFR_BITS-1:0]       refractory;
		logic [SAMPLE_BITS_DEF-1:0] prev_level;
		logic [TIME_BITS_DEF-1:0]   last_beat_ms;
		beat_rec_t                  pending_beats[$];
		int                         mismatches;
		int                         beats_checked;

		function new();
			threshold     = THRESH_RESET;
			refractory    = REFR_RESET;
			prev_level    = '0;
			last_beat_ms  = '0;
			mismatches    = 0;
			beats_checked = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [31:0] data);
			case (idx)
				REG_THRESHOLD: begin
					threshold = data[THRESH_BITS-1:0];
				end
				REG_REFRACTORY: begin
					refractory = data[REFR_BITS-1:0];
				end
				default: begin
				end
			endcase
		endfunction

		// rate rounded to nearest, halves up
		function logic [BPM_BITS-1:0] bpm_from_interval(logic [IVL_BITS-1:0] ivl);
			longint unsigned num;
			longint unsigned den;
			longint unsigned q;
			if (ivl == '0)
				return '0;
			num = 64'(RATE_NUMER) + 64'(ivl);
			den = 64'(ivl) << 1;
			q = num / den;
			return q[BPM_BITS-1:0];
		endfunction

		function void note_sample(logic [SAMPLE_BITS_DEF-1:0] level,
				logic [TIME_BITS_DEF-1:0] now);
			logic [TIME_BITS_DEF-1:0] gap;
			beat_rec_t rec;
			if (level > threshold && prev_level <= threshold) begin
				gap = now - last_beat_ms;
				if (gap > refractory) begin
					rec.bpm = bpm_from_interval(gap);
					rec.ivl = gap;
					pending_beats.push_back(rec);
					last_beat_ms = now;
				end
			end
			prev_level = level;
		endfunction

		function void check_beat(logic [BPM_BITS-1:0] bpm, logic [IVL_BITS-1:0] ivl);
			beat_rec_t want;
			if (pending_beats.size() == 0) begin
				$display("%0t: unexpected beat, got bpm %0d interval %0d", $time, bpm, ivl);
				mismatches++;
				return;
			end
			want = pending_beats.pop_front();
			beats_checked++;
			if (bpm !== want.bpm) begin
				$display("%0t: beats_per_minute mismatch, expected %0d, got %0d",
					$time, want.bpm, bpm);
				mismatches++;
			end
			if (ivl !== want.ivl) begin
				$display("%0t: interval_ms mismatch, expected %0d, got %0d",
					$time, want.ivl, ivl);
				mismatches++;
			end
		endfunction
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       sample_valid = 1'b0;
	logic                       sample_ready;
	logic [SAMPLE_BITS_DEF-1:0] sample_value = '0;
	logic [TIME_BITS_DEF-1:0]   time_ms = '0;
	logic                       beat_valid;
	logic                       beat_ready = 1'b0;
	logic [BPM_BITS-1:0]        beats_per_minute;
	logic [IVL_BITS-1:0]        interval_ms;
	logic                       psel = 1'b0;
	logic                       penable = 1'b0;
	logic                       pwrite = 1'b0;
	logic [ADDR_BITS-1:0]       paddr = '0;
	logic [31:0]                pwdata = '0;
	logic [31:0]                prdata;
	logic                       pready;

	beat_scoreboard           beat_sb;
	logic [TIME_BITS_DEF-1:0] sim_ms;

	pulse_rate_detector_core i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.sample_valid     (sample_valid),
		.sample_ready     (sample_ready),
		.sample_value     (sample_value),
		.time_ms          (time_ms),
		.beat_valid       (beat_valid),
		.beat_ready       (beat_ready),
		.beats_per_minute (beats_per_minute),
		.interval_ms      (interval_ms),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_valid && sample_ready)
				beat_sb.note_sample(sample_value, time_ms);
			if (beat_valid && beat_ready)
				beat_sb.check_beat(beats_per_minute, interval_ms);
		end
	end

	task automatic send_sample(input logic [SAMPLE_BITS_DEF-1:0] level,
			input logic [TIME_BITS_DEF-1:0] now);
		sample_value <= level;
		time_ms      <= now;
		sample_valid <= 1'b1;
		do
			@(posedge clk);
		while (!sample_ready);
	endtask

	task automatic pause_samples(input int cycles);
		sample_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic wait_for_beats();
		sample_valid <= 1'b0;
		do
			@(posedge clk);
		while (beat_sb.pending_beats.size() != 0);
	endtask

	task automatic apb_write(input reg_idx_t idx, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		beat_sb.write_reg(idx, data);
		@(posedge clk);
	endtask

	// junk in the upper bits must be dropped
	task automatic configure(input int thr, input int refr);
		logic [31:0] junk;
		junk = $urandom;
		wait_for_beats();
		repeat (40) @(posedge clk);
		apb_write(REG_THRESHOLD, {junk[31:THRESH_BITS], thr[THRESH_BITS-1:0]});
		junk = $urandom;
		apb_write(REG_REFRACTORY, {junk[31:REFR_BITS], refr[REFR_BITS-1:0]});
	endtask

	task automatic run_phase(input int count);
		int                         thr;
		int                         step_max;
		int                         burst_left;
		int                         pulse_pos;
		int                         pulse_len;
		int                         low_n;
		logic [SAMPLE_BITS_DEF-1:0] level;
		thr        = int'(beat_sb.threshold);
		step_max   = int'(beat_sb.refractory) / 2 + 4;
		burst_left = 0;
		pulse_pos  = 0;
		pulse_len  = 0;
		low_n      = 0;
		for (int i = 0; i < count; i++) begin
			if (i == count / 2)
				wait_for_beats();
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 30);
				if ($urandom_range(0, 2) != 0)
					pause_samples($urandom_range(1, 12));
			end
			burst_left--;
			if ($urandom_range(0, 11) == 0) begin
				// noise: any level, any jump of the ms counter
				level  = SAMPLE_BITS_DEF'($urandom);
				sim_ms = $urandom;
			end else begin
				if (pulse_pos == pulse_len) begin
					low_n     = $urandom_range(1, 4);
					pulse_len = low_n + $urandom_range(1, 3);
					pulse_pos = 0;
				end
				if (pulse_pos < low_n)
					level = SAMPLE_BITS_DEF'($urandom_range(0, thr));
				else if (thr >= 1023)
					level = 10'd1023;
				else
					level = SAMPLE_BITS_DEF'($urandom_range(thr + 1, 1023));
				pulse_pos++;
				sim_ms = sim_ms + $urandom_range(0, step_max);
			end
			send_sample(level, sim_ms);
		end
	endtask

	// output side stall patterns, with one long hold-off
	initial begin
		int seg;
		int mode;
		bit held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			seg  = $urandom_range(20, 150);
			mode = $urandom_range(0, 3);
			repeat (seg) begin
				@(posedge clk);
				if (!held && beat_sb.beats_checked >= 30) begin
					held = 1'b1;
					beat_ready <= 1'b0;
					repeat (600) @(posedge clk);
				end
				case (mode)
					0: beat_ready <= 1'b1;
					1: beat_ready <= 1'($urandom_range(0, 1));
					2: beat_ready <= ($urandom_range(0, 3) == 0);
					default: beat_ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	initial begin
		beat_sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first crossing measured from time zero, inside refractory
		send_sample(10'd0, 32'd0);
		send_sample(10'd650, 32'd10);
		send_sample(10'd651, 32'd250);
		send_sample(10'd0, 32'd260);
		send_sample(10'd1023, 32'd301);
		// interval equal to refractory is rejected, one more is accepted
		send_sample(10'd300, 32'd400);
		send_sample(10'd700, 32'd601);
		send_sample(10'd649, 32'd602);
		send_sample(10'd700, 32'd602);
		send_sample(10'd1023, 32'd1000);
		// huge interval, then a beat across the counter wrap
		send_sample(10'd0, 32'hFFFF_FF00);
		send_sample(10'd800, 32'hFFFF_FF00);
		send_sample(10'd0, 32'hFFFF_FFFF);
		send_sample(10'd900, 32'h0000_0100);
		send_sample(10'h155, 32'h5555_5555);
		send_sample(10'h2AA, 32'hAAAA_AAAA);

		// zero interval rejected, one ms gives the top rate
		configure(0, 0);
		send_sample(10'd0, 32'hAAAA_AAAA);
		send_sample(10'd1, 32'hAAAA_AAAA);
		send_sample(10'd0, 32'hAAAA_AAAB);
		send_sample(10'd1, 32'hAAAA_AAAB);
		sim_ms = 32'hAAAA_AAAB;

		run_phase(130);
		configure(1023, 65535);
		run_phase(60);
		configure(512, 65535);
		run_phase(130);
		configure(1000, 0);
		run_phase(130);
		configure(3, 150);
		run_phase(130);
		configure($urandom_range(0, 1023), $urandom_range(0, 2000));
		run_phase(130);
		configure(650, 300);
		run_phase(130);

		wait_for_beats();
		repeat (50) @(posedge clk);
		if (beat_sb.mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#3000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
